### rtl/kftt_pkg.sv
// Package for the keyed freeze timeout table: sizes, action/event/status codes,
// item structs and the controller/datapath command and status structs.
// No dependencies.
package kftt_pkg;

   localparam int ENTRIES  = 16;
   localparam int KEY_BITS = 16;
   localparam int IDX_BITS = $clog2(ENTRIES);
   localparam int CNT_BITS = $clog2(ENTRIES + 1);

   localparam logic [2:0] ACT_REGISTER   = 3'd0;
   localparam logic [2:0] ACT_UNREGISTER = 3'd1;
   localparam logic [2:0] ACT_FREEZE     = 3'd2;
   localparam logic [2:0] ACT_RELEASE    = 3'd3;
   localparam logic [2:0] ACT_TICK       = 3'd4;

   localparam logic [1:0] EV_STATUS = 2'd0;
   localparam logic [1:0] EV_RESUME = 2'd1;
   localparam logic [1:0] EV_PAUSE  = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_DUPLICATE = 3'd2;
   localparam logic [2:0] ST_NULL      = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] actor_id;
      logic [15:0] actor_handle;
      logic        infinite;
      logic [31:0] duration;
      logic [15:0] delta_ticks;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [15:0] actor_id_res;
      logic [15:0] actor_handle_res;
      logic [2:0]  status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic walk_step;
      logic walk_final;
   } cmd_type;

   typedef struct packed {
      logic is_tick;
      logic walk_done;
   } stat_type;

endpackage

### rtl/kftt_ctrl.sv
// Controller of the keyed freeze timeout table: sequences load, execute
// and the tick walk over the freeze order. Depends on kftt_pkg.
module kftt_ctrl import kftt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_WALK = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.is_tick ? S_WALK : S_IDLE;
         end
         S_WALK: begin
            if (stat.walk_done) begin
               cmd.walk_final = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

### rtl/kftt_datapath.sv
// Datapath of the keyed freeze timeout table: slot registers, parallel key
// match, freeze-order queue, saturating timer update and result register.
// Depends on kftt_pkg.
module kftt_datapath import kftt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_item,
   input  cmd_type  cmd,
   output stat_type stat,
   output rsp_type  rsp_item,
   output logic     rsp_valid
);

   req_type item_ff;

   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [ENTRIES-1:0]  frozen_ff, frozen_in;
   logic [KEY_BITS-1:0] key_ff     [ENTRIES];
   logic [15:0]         handle_ff  [ENTRIES];
   logic                forever_ff [ENTRIES];
   logic [31:0]         limit_ff   [ENTRIES];
   logic [31:0]         elapsed_ff [ENTRIES];
   logic [IDX_BITS-1:0] order_ff   [ENTRIES];
   logic [IDX_BITS-1:0] order_in   [ENTRIES];
   logic [IDX_BITS-1:0] order_unlink [ENTRIES];
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS-1:0] remain_ff, remain_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [KEY_BITS-1:0] key_cur;
   logic [ENTRIES-1:0]  hit;
   logic [ENTRIES-2:0]  del_hit, del_after;
   logic                found, full, reg_ok, freeze_add;
   logic [IDX_BITS-1:0] hit_idx, free_idx, head, rd_idx, tail_idx;
   logic [32:0]         sum;
   logic [31:0]         elapsed_new;
   logic                expired;

   assign key_cur = KEY_BITS'(item_ff.actor_id);

   always_comb begin
      hit      = '0;
      hit_idx  = '0;
      free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         hit[i] = valid_ff[i] && (key_ff[i] == key_cur);
         if (hit[i]) begin
            hit_idx = IDX_BITS'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = IDX_BITS'(i);
         end
      end
   end

   assign found  = |hit;
   assign full   = &valid_ff;
   assign reg_ok = (item_ff.actor_handle != 16'd0) && !found && !full;
   assign freeze_add = !frozen_ff[hit_idx] && (count_ff < CNT_BITS'(ENTRIES));

   // removal of hit_idx from the freeze order: entries at and after it move up
   always_comb begin
      for (int i = 0; i < ENTRIES - 1; i++) begin
         del_hit[i] = (CNT_BITS'(i) < count_ff) && (order_ff[i] == hit_idx);
      end
      del_after[0] = del_hit[0];
      for (int i = 1; i < ENTRIES - 1; i++) begin
         del_after[i] = del_after[i-1] | del_hit[i];
      end
      for (int i = 0; i < ENTRIES - 1; i++) begin
         order_unlink[i] = del_after[i] ? order_ff[i+1] : order_ff[i];
      end
      order_unlink[ENTRIES-1] = order_ff[ENTRIES-1];
   end

   assign head     = order_ff[0];
   assign rd_idx   = cmd.walk_step ? head : hit_idx;
   assign tail_idx = IDX_BITS'(count_ff - CNT_BITS'(1));

   assign sum         = {1'b0, elapsed_ff[head]} + {17'd0, item_ff.delta_ticks};
   assign elapsed_new = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   assign expired     = !forever_ff[head] && (elapsed_new >= limit_ff[head]);

   always_comb begin
      valid_in     = valid_ff;
      frozen_in    = frozen_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      order_in     = order_ff;
      rsp_in       = '0;
      rsp_valid_in = 1'b0;
      if (cmd.exec) begin
         rsp_in.last  = 1'b1;
         rsp_valid_in = 1'b1;
         case (item_ff.action)
            ACT_REGISTER: begin
               rsp_in.actor_id_res     = item_ff.actor_id;
               rsp_in.actor_handle_res = item_ff.actor_handle;
               if (item_ff.actor_handle == 16'd0) begin
                  rsp_in.status = ST_NULL;
               end else if (found) begin
                  rsp_in.status = ST_DUPLICATE;
               end else if (full) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  valid_in[free_idx]  = 1'b1;
                  frozen_in[free_idx] = 1'b0;
               end
            end
            ACT_UNREGISTER, ACT_FREEZE, ACT_RELEASE: begin
               rsp_in.actor_id_res = item_ff.actor_id;
               if (!found) begin
                  rsp_in.status = ST_NOT_FOUND;
               end else begin
                  rsp_in.actor_handle_res = handle_ff[rd_idx];
                  if (item_ff.action == ACT_FREEZE) begin
                     rsp_in.event_kind = EV_PAUSE;
                     if (freeze_add) begin
                        order_in[count_ff[IDX_BITS-1:0]] = hit_idx;
                        count_in           = count_ff + CNT_BITS'(1);
                        frozen_in[hit_idx] = 1'b1;
                     end
                  end else begin
                     if (item_ff.action == ACT_RELEASE) begin
                        rsp_in.event_kind = EV_RESUME;
                     end else begin
                        valid_in[hit_idx] = 1'b0;
                     end
                     if (frozen_ff[hit_idx]) begin
                        order_in           = order_unlink;
                        count_in           = count_ff - CNT_BITS'(1);
                        frozen_in[hit_idx] = 1'b0;
                     end
                  end
               end
            end
            ACT_TICK: begin
               rsp_in.last  = 1'b0;
               rsp_valid_in = 1'b0;
               remain_in    = count_ff;
            end
            default: begin
               rsp_in.status = ST_OK;
            end
         endcase
      end else if (cmd.walk_step) begin
         remain_in = remain_ff - CNT_BITS'(1);
         for (int i = 0; i < ENTRIES - 1; i++) begin
            order_in[i] = order_ff[i+1];
         end
         if (expired) begin
            count_in                = count_ff - CNT_BITS'(1);
            frozen_in[head]         = 1'b0;
            rsp_valid_in            = 1'b1;
            rsp_in.event_kind       = EV_RESUME;
            rsp_in.actor_id_res     = 16'(key_ff[rd_idx]);
            rsp_in.actor_handle_res = handle_ff[rd_idx];
         end else begin
            order_in[tail_idx] = head;
         end
      end else if (cmd.walk_final) begin
         rsp_valid_in = 1'b1;
         rsp_in.last  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         frozen_ff    <= '0;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         frozen_ff    <= frozen_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      order_ff <= order_in;
      rsp_ff   <= rsp_in;
      if (cmd.load) begin
         item_ff <= req_item;
      end
      if (cmd.exec && (item_ff.action == ACT_REGISTER) && reg_ok) begin
         key_ff[free_idx]    <= key_cur;
         handle_ff[free_idx] <= item_ff.actor_handle;
      end
      if (cmd.exec && (item_ff.action == ACT_FREEZE) && found) begin
         forever_ff[hit_idx] <= item_ff.infinite;
         limit_ff[hit_idx]   <= item_ff.duration;
         elapsed_ff[hit_idx] <= 32'd0;
      end
      if (cmd.walk_step && !forever_ff[head]) begin
         elapsed_ff[head] <= elapsed_new;
      end
   end

   assign stat.is_tick   = (item_ff.action == ACT_TICK);
   assign stat.walk_done = (remain_ff == '0);
   assign rsp_item       = rsp_ff;
   assign rsp_valid      = rsp_valid_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(ENTRIES))
      else $error("freeze count exceeds table size");
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      $countones(frozen_ff) == int'(count_ff))
      else $error("freeze count differs from frozen flags");
   a_frozen_valid: assert property (@(posedge clock) disable iff (reset)
      (frozen_ff & ~valid_ff) == '0)
      else $error("frozen flag on a free slot");
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> (remain_ff <= count_ff))
      else $error("walk remainder exceeds queue length");
`endif

endmodule

### rtl/keyed_freeze_timeout_table_core.sv
// Top level of the keyed freeze timeout table.
// Depends on kftt_pkg, kftt_ctrl and kftt_datapath.
//
// Usage:
//   Command channel: drive req_item and raise start; the item is taken at a
//   rising edge where start is high and busy is low.
//   Result channel: each result sits on rsp_item for one cycle with
//   rsp_valid high; rsp_item.last marks the final result of an item. The
//   receiver has no way to hold results off and must take every one.
//   Register, unregister, freeze, release and unused actions give one
//   result, registered after the execute state; busy is high for one
//   cycle, so a further item can be taken as soon as busy drops.
//   A tick walks the freeze order one entry per cycle, emitting a resume
//   result for each expired entry as it goes, then a closing status result.
//   It visits each frozen entry once, through the single timer adder that
//   updates the head of the freeze order.
//   Key lookup compares all slots at once.
//   Reset empties the table and the freeze order and drops any result.
module keyed_freeze_timeout_table_core import kftt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   cmd_type  cmd;
   stat_type stat;

   kftt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   kftt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_item  (rsp_item),
      .rsp_valid (rsp_valid)
   );

endmodule

### tb/tb_keyed_freeze_timeout_table_core.sv
// Self-checking testbench for keyed_freeze_timeout_table_core: directed, full-table,
// long-timer and random traffic, checked against an in-bench table predictor.
// Depends on kftt_pkg and the RTL of the core.
module tb_keyed_freeze_timeout_table_core;
   timeunit 1ns;
   timeprecision 1ps;
   import kftt_pkg::*;

   localparam logic [2:0] ACT_SPARE_LO = 3'd5;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;
   localparam int KEY_POOL = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   // predicted table contents
   bit          tbl_used    [ENTRIES];
   logic [15:0] tbl_key     [ENTRIES];
   logic [15:0] tbl_handle  [ENTRIES];
   bit          tbl_paused  [ENTRIES];
   bit          tbl_forever [ENTRIES];
   logic [31:0] tbl_limit   [ENTRIES];
   logic [31:0] tbl_elapsed [ENTRIES];
   int          pause_order [$];
   rsp_type     pending_events [$];

   logic [15:0] key_pool [KEY_POOL];
   int sender_idle_pct = 0;
   int items_sent = 0;
   int results_checked = 0;
   int errors = 0;

   keyed_freeze_timeout_table_core uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always #2 clock = ~clock;

   function automatic rsp_type make_rsp(logic [1:0] kind, logic [15:0] id, logic [15:0] handle,
                                        logic [2:0] st, logic lst);
      rsp_type r;
      r.event_kind       = kind;
      r.actor_id_res     = id;
      r.actor_handle_res = handle;
      r.status           = st;
      r.last             = lst;
      return r;
   endfunction

   function automatic req_type make_req(logic [2:0] act, logic [15:0] id, logic [15:0] handle,
                                        logic inf, logic [31:0] dur, logic [15:0] delta);
      req_type it;
      it.action       = act;
      it.actor_id     = id;
      it.actor_handle = handle;
      it.infinite     = inf;
      it.duration     = dur;
      it.delta_ticks  = delta;
      return it;
   endfunction

   function automatic void queue_event(rsp_type r);
      pending_events.insert(pending_events.size(), r);
   endfunction

   function automatic int lookup_key(logic [15:0] key);
      for (int i = 0; i < ENTRIES; i++)
         if (tbl_used[i] && tbl_key[i] == key) return i;
      return -1;
   endfunction

   function automatic void unpause_slot(int s);
      for (int i = pause_order.size() - 1; i >= 0; i--)
         if (pause_order[i] == s) pause_order.delete(i);
      tbl_paused[s] = 1'b0;
   endfunction

   function automatic void predict_events(req_type it);
      int s;
      int free_slot;
      int q;
      int kept [$];
      logic [32:0] sum;
      logic [31:0] e;
      case (it.action)
         ACT_REGISTER: begin
            free_slot = -1;
            for (int i = 0; i < ENTRIES; i++)
               if (!tbl_used[i] && free_slot < 0) free_slot = i;
            if (it.actor_handle == 16'd0)
               queue_event(make_rsp(EV_STATUS, it.actor_id, it.actor_handle, ST_NULL, 1'b1));
            else if (lookup_key(it.actor_id) >= 0)
               queue_event(make_rsp(EV_STATUS, it.actor_id, it.actor_handle,
                                    ST_DUPLICATE, 1'b1));
            else if (free_slot < 0)
               queue_event(make_rsp(EV_STATUS, it.actor_id, it.actor_handle, ST_FULL, 1'b1));
            else begin
               tbl_used[free_slot]   = 1'b1;
               tbl_key[free_slot]    = it.actor_id;
               tbl_handle[free_slot] = it.actor_handle;
               tbl_paused[free_slot] = 1'b0;
               queue_event(make_rsp(EV_STATUS, it.actor_id, it.actor_handle, ST_OK, 1'b1));
            end
         end
         ACT_UNREGISTER, ACT_FREEZE, ACT_RELEASE: begin
            s = lookup_key(it.actor_id);
            if (s < 0)
               queue_event(make_rsp(EV_STATUS, it.actor_id, 16'd0, ST_NOT_FOUND, 1'b1));
            else if (it.action == ACT_UNREGISTER) begin
               if (tbl_paused[s]) unpause_slot(s);
               tbl_used[s] = 1'b0;
               queue_event(make_rsp(EV_STATUS, it.actor_id, tbl_handle[s], ST_OK, 1'b1));
            end else if (it.action == ACT_FREEZE) begin
               if (!tbl_paused[s]) begin
                  pause_order.insert(pause_order.size(), s);
                  tbl_paused[s] = 1'b1;
               end
               tbl_forever[s] = it.infinite;
               tbl_limit[s]   = it.duration;
               tbl_elapsed[s] = 32'd0;
               queue_event(make_rsp(EV_PAUSE, it.actor_id, tbl_handle[s], ST_OK, 1'b1));
            end else begin
               if (tbl_paused[s]) unpause_slot(s);
               queue_event(make_rsp(EV_RESUME, it.actor_id, tbl_handle[s], ST_OK, 1'b1));
            end
         end
         ACT_TICK: begin
            foreach (pause_order[t]) begin
               q = pause_order[t];
               if (!tbl_forever[q]) begin
                  sum = {1'b0, tbl_elapsed[q]} + {17'd0, it.delta_ticks};
                  e = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                  tbl_elapsed[q] = e;
                  if (e >= tbl_limit[q]) begin
                     tbl_paused[q] = 1'b0;
                     queue_event(make_rsp(EV_RESUME, tbl_key[q], tbl_handle[q], ST_OK, 1'b0));
                     continue;
                  end
               end
               kept.insert(kept.size(), q);
            end
            pause_order = kept;
            queue_event(make_rsp(EV_STATUS, 16'd0, 16'd0, ST_OK, 1'b1));
         end
         default:
            queue_event(make_rsp(EV_STATUS, 16'd0, 16'd0, ST_OK, 1'b1));
      endcase
   endfunction

   task automatic send_item(input req_type it);
      bit idle_seen;
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_item <= it;
      start    <= 1'b1;
      // busy is sampled mid-cycle, so the accepting edge is seen without a race
      forever begin
         @(negedge clock);
         idle_seen = !busy;
         @(posedge clock);
         if (idle_seen) break;
      end
      predict_events(it);
      items_sent++;
   endtask

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // each result is held for one full cycle; sample it mid-cycle
   always @(negedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_events.size() == 0) begin
            $display("%0t ns: unexpected result, expected none actual %h", $time, rsp_item);
            errors++;
         end else begin
            want = pending_events.pop_front();
            results_checked++;
            check_field("event_kind", 16'(want.event_kind), 16'(rsp_item.event_kind));
            check_field("actor_id_res", want.actor_id_res, rsp_item.actor_id_res);
            check_field("actor_handle_res", want.actor_handle_res, rsp_item.actor_handle_res);
            check_field("status", 16'(want.status), 16'(rsp_item.status));
            check_field("last", 16'(want.last), 16'(rsp_item.last));
         end
      end
   end

   task automatic test_directed_basics();
      send_item(make_req(ACT_REGISTER,   16'h0000, 16'h0000, 1'b0, 32'd0, 16'd0));
      send_item(make_req(ACT_REGISTER,   16'h0000, 16'h0001, 1'b0, 32'd0, 16'd0));
      send_item(make_req(ACT_REGISTER,   16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 16'hFFFF));
      send_item(make_req(ACT_REGISTER,   16'hFFFF, 16'h1234, 1'b0, 32'd0, 16'd0));
      send_item(make_req(ACT_UNREGISTER, 16'h5555, 16'h0000, 1'b0, 32'd0, 16'd0));
      send_item(make_req(ACT_FREEZE,     16'hAAAA, 16'h0000, 1'b1, 32'd0, 16'd0));
      send_item(make_req(ACT_RELEASE,    16'h1357, 16'h0000, 1'b0, 32'd0, 16'd0));
      send_item(make_req(ACT_FREEZE,     16'h0000, 16'h0000, 1'b1, 32'hFFFF_FFFF, 16'd0));
      // zero duration expires on the next tick even with zero delta
      send_item(make_req(ACT_FREEZE,     16'hFFFF, 16'h0000, 1'b0, 32'd0, 16'd0));
      send_item(make_req(ACT_TICK,       16'h0000, 16'h0000, 1'b0, 32'd0, 16'd0));
      send_item(make_req(ACT_TICK,       16'h0000, 16'h0000, 1'b0, 32'd0, 16'hFFFF));
      send_item(make_req(ACT_RELEASE,    16'h0000, 16'h0000, 1'b0, 32'd0, 16'd0));
      send_item(make_req(ACT_RELEASE,    16'hFFFF, 16'h0000, 1'b0, 32'd0, 16'd0));
      send_item(make_req(ACT_FREEZE,     16'hFFFF, 16'h0000, 1'b0, 32'd10, 16'd0));
      send_item(make_req(ACT_FREEZE,     16'h0000, 16'h0000, 1'b0, 32'd5, 16'd0));
      // refreeze keeps its place in order, restarts count
      send_item(make_req(ACT_FREEZE,     16'hFFFF, 16'h0000, 1'b0, 32'd6, 16'd0));
      send_item(make_req(ACT_TICK,       16'h0000, 16'h0000, 1'b0, 32'd0, 16'd5));
      send_item(make_req(ACT_TICK,       16'h0000, 16'h0000, 1'b0, 32'd0, 16'd1));
      send_item(make_req(ACT_UNREGISTER, 16'h0000, 16'h0000, 1'b0, 32'd0, 16'd0));
      send_item(make_req(ACT_FREEZE,     16'hFFFF, 16'h0000, 1'b1, 32'd0, 16'd0));
      send_item(make_req(ACT_UNREGISTER, 16'hFFFF, 16'h0000, 1'b0, 32'd0, 16'd0));
      send_item(make_req(ACT_TICK,       16'h0000, 16'h0000, 1'b0, 32'd0, 16'd3));
      send_item(make_req(ACT_SPARE_LO,   16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 16'hFFFF));
      send_item(make_req(ACT_SPARE_HI,   16'h1234, 16'h5678, 1'b0, 32'd7, 16'd9));
   endtask

   task automatic test_table_full();
      logic [15:0] keys [$];
      for (int k = 0; k <= ENTRIES; k++)
         send_item(make_req(ACT_REGISTER, 16'h8000 + 16'(k), 16'h0100 + 16'(k),
                            1'b0, 32'd0, 16'd0));
      for (int i = ENTRIES - 1; i >= 0; i--)
         if (tbl_used[i]) keys.insert(keys.size(), tbl_key[i]);
      foreach (keys[i])
         send_item(make_req(ACT_FREEZE, keys[i], 16'h0000, 1'b0,
                            32'($urandom_range(16'hFFFF)), 16'd0));
      // every slot expires in one walk
      send_item(make_req(ACT_TICK, 16'h0000, 16'h0000, 1'b0, 32'd0, 16'hFFFF));
   endtask

   task automatic test_long_timer();
      logic [15:0] keys [$];
      for (int i = 0; i < ENTRIES; i++)
         if (tbl_used[i]) keys.insert(keys.size(), tbl_key[i]);
      foreach (keys[i])
         send_item(make_req(ACT_UNREGISTER, keys[i], 16'h0000, 1'b0, 32'd0, 16'd0));
      send_item(make_req(ACT_REGISTER, 16'h4242, 16'hBEEF, 1'b0, 32'd0, 16'd0));
      send_item(make_req(ACT_FREEZE, 16'h4242, 16'h0000, 1'b0, 32'hFFFF_FFFF, 16'd0));
      // elapsed climbs by max delta without reaching the limit
      repeat (4)
         send_item(make_req(ACT_TICK, 16'h0000, 16'h0000, 1'b0, 32'd0, 16'hFFFF));
      send_item(make_req(ACT_TICK, 16'h0000, 16'h0000, 1'b0, 32'd0, 16'd1));
      send_item(make_req(ACT_TICK, 16'h0000, 16'h0000, 1'b0, 32'd0, 16'hFFFF));
   endtask

   task automatic test_random_traffic(input int idle_pct, input int count);
      req_type it;
      int unsigned pick;
      sender_idle_pct = idle_pct;
      repeat (count) begin
         it.actor_id     = 16'($urandom);
         it.actor_handle = 16'($urandom);
         it.infinite     = 1'($urandom);
         it.duration     = $urandom;
         it.delta_ticks  = 16'($urandom);
         pick = $urandom_range(99);
         if (pick < 22) it.action = ACT_REGISTER;
         else if (pick < 30) it.action = ACT_UNREGISTER;
         else if (pick < 55) it.action = ACT_FREEZE;
         else if (pick < 65) it.action = ACT_RELEASE;
         else if (pick < 97) it.action = ACT_TICK;
         else it.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
         if ($urandom_range(99) < 85) it.actor_id = key_pool[$urandom_range(KEY_POOL - 1)];
         if ($urandom_range(99) < 6) it.actor_handle = 16'h0000;
         else if (it.actor_handle == 16'h0000) it.actor_handle = 16'h0001;
         it.infinite = ($urandom_range(3) == 0);
         pick = $urandom_range(99);
         if (pick < 70) it.duration = $urandom_range(400);
         else if (pick < 80) it.duration = 32'd0;
         if ($urandom_range(99) < 75) it.delta_ticks = 16'($urandom_range(120));
         send_item(it);
      end
   endtask

   initial begin
      foreach (key_pool[i]) key_pool[i] = 16'($urandom);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_basics();
      test_table_full();
      test_long_timer();
      test_random_traffic(0, 80);
      test_random_traffic(46, 80);
      test_random_traffic(14, 80);
      start <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("summary: %0d items (directed, full table, long timer, random)", items_sent);
      $display("summary: %0d results checked, %0d mismatches", results_checked, errors);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

### sim.f
rtl/kftt_pkg.sv
rtl/kftt_ctrl.sv
rtl/kftt_datapath.sv
rtl/keyed_freeze_timeout_table_core.sv
tb/tb_keyed_freeze_timeout_table_core.sv
